// ===== hw/rtl/tfbe_pkg.sv =====
// Shared types and constants for the typed field byte encoder.
// No dependencies; imported by every module of the block.
package tfbe_pkg;

  typedef enum logic [3:0] {
    KIND_U8,
    KIND_U16,
    KIND_U32,
    KIND_BOOL,
    KIND_I8_TAG,
    KIND_U8_TAG,
    KIND_I16_TAG,
    KIND_U16_TAG,
    KIND_I32_TAG,
    KIND_U32_TAG,
    KIND_DEC16,
    KIND_DEC24,
    KIND_DEC32
  } kind_e;

  localparam logic [7:0] BOOL_TRUE   = 8'h11;
  localparam logic [7:0] BOOL_FALSE  = 8'h10;
  localparam logic [7:0] TAG_DEC16   = 8'h0b;
  localparam logic [7:0] TAG_DEC24   = 8'h0c;
  localparam logic [7:0] TAG_DEC32   = 8'h0d;
  localparam logic [7:0] TAG_OFFSET  = 8'd3;

  localparam int unsigned MaxBytes = 5;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  typedef struct packed {
    logic        err;
    logic [3:0]  kind;
    logic [31:0] value;
    logic [7:0]  scale;
  } dec_t;

  typedef struct packed {
    logic                          err;
    logic [MaxBytes-1:0][7:0]      bytes;
    logic [CntW-1:0]               cnt;
  } pk_t;

endpackage

// ===== hw/rtl/typed_field_byte_encoder.sv =====
// Typed field byte encoder top level: decode, pack and serialise stages.
// Depends on tfbe_pkg, tfbe_decode, tfbe_pack and tfbe_serial.
//
// Encodes one typed value per input transfer into its wire bytes, most
// significant first, one output transfer per byte with tlast on the final
// byte. An item has one to five bytes; the byte serialiser sets the
// sustained rate at one byte per cycle while m_axis_tready is high, and
// a waiting item follows the previous one's last byte without a gap. An
// input transfer passes the decode, pack and serial registers before its
// first output byte. A decimal out of range, or an undefined kind, gives
// one transfer with tuser set, tdata zero and tlast set.
module typed_field_byte_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] value, [39:32] scale
  input  logic [3:0]  s_axis_tuser,   // [3:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] range_error
);
  import tfbe_pkg::*;

  logic dec_valid, dec_ready;
  dec_t dec_data;
  logic pk_valid, pk_ready;
  pk_t  pk_data;

  tfbe_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .value_i     (s_axis_tdata[31:0]),
    .scale_i     (s_axis_tdata[39:32]),
    .out_valid_o (dec_valid),
    .out_ready_i (dec_ready),
    .out_o       (dec_data)
  );

  tfbe_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .in_i        (dec_data),
    .out_valid_o (pk_valid),
    .out_ready_i (pk_ready),
    .out_o       (pk_data)
  );

  tfbe_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pk_valid),
    .in_ready_o  (pk_ready),
    .in_i        (pk_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

endmodule

// ===== hw/rtl/tfbe_decode.sv =====
// First stage: classify the kind and range-check decimal scale and significand.
// Depends on tfbe_pkg.
module tfbe_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [3:0]    kind_i,
  input  logic [31:0]   value_i,
  input  logic [7:0]    scale_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tfbe_pkg::dec_t out_o
);
  import tfbe_pkg::*;

  logic valid_q;
  dec_t data_q, data_d;
  logic err;

  always_comb begin
    err = 1'b0;
    unique case (kind_e'(kind_i))
      KIND_U8, KIND_U16, KIND_U32, KIND_BOOL, KIND_I8_TAG, KIND_U8_TAG,
      KIND_I16_TAG, KIND_U16_TAG, KIND_I32_TAG, KIND_U32_TAG: err = 1'b0;
      KIND_DEC16: begin
        err = !((value_i[15:12] == 4'h0) || (value_i[15:12] == 4'hf)) ||
              !((scale_i[7:2] == 6'h00) || (scale_i[7:2] == 6'h3f));
      end
      KIND_DEC24: begin
        err = !((value_i[31:19] == 13'h0000) || (value_i[31:19] == 13'h1fff)) ||
              !((scale_i[7:3] == 5'h00) || (scale_i[7:3] == 5'h1f));
      end
      KIND_DEC32: begin
        err = !((value_i[31:26] == 6'h00) || (value_i[31:26] == 6'h3f)) ||
              !((scale_i[7:4] == 4'h0) || (scale_i[7:4] == 4'hf));
      end
      default: err = 1'b1;
    endcase
    data_d = '{err: err, kind: kind_i, value: value_i, scale: scale_i};
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hw/rtl/tfbe_pack.sv =====
// Second stage: build the wire bytes and byte count for one item.
// Depends on tfbe_pkg.
module tfbe_pack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tfbe_pkg::dec_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tfbe_pkg::pk_t  out_o
);
  import tfbe_pkg::*;

  logic valid_q;
  pk_t  data_q, data_d;
  logic [31:0] v;
  logic [7:0]  s;
  logic [7:0]  tag;

  always_comb begin
    v   = in_i.value;
    s   = in_i.scale;
    tag = {4'h0, in_i.kind} - TAG_OFFSET;
    data_d = '{err: 1'b0, bytes: '0, cnt: CntW'(1)};
    case (kind_e'(in_i.kind))
      KIND_U8: begin
        data_d.bytes[0] = v[7:0];
        data_d.cnt      = CntW'(1);
      end
      KIND_U16: begin
        data_d.bytes[0] = v[15:8];
        data_d.bytes[1] = v[7:0];
        data_d.cnt      = CntW'(2);
      end
      KIND_U32: begin
        data_d.bytes[0] = v[31:24];
        data_d.bytes[1] = v[23:16];
        data_d.bytes[2] = v[15:8];
        data_d.bytes[3] = v[7:0];
        data_d.cnt      = CntW'(4);
      end
      KIND_BOOL: begin
        data_d.bytes[0] = (|v[7:0]) ? BOOL_TRUE : BOOL_FALSE;
        data_d.cnt      = CntW'(1);
      end
      KIND_I8_TAG, KIND_U8_TAG: begin
        data_d.bytes[0] = tag;
        data_d.bytes[1] = v[7:0];
        data_d.cnt      = CntW'(2);
      end
      KIND_I16_TAG, KIND_U16_TAG: begin
        data_d.bytes[0] = tag;
        data_d.bytes[1] = v[15:8];
        data_d.bytes[2] = v[7:0];
        data_d.cnt      = CntW'(3);
      end
      KIND_I32_TAG, KIND_U32_TAG: begin
        data_d.bytes[0] = tag;
        data_d.bytes[1] = v[31:24];
        data_d.bytes[2] = v[23:16];
        data_d.bytes[3] = v[15:8];
        data_d.bytes[4] = v[7:0];
        data_d.cnt      = CntW'(5);
      end
      KIND_DEC16: begin
        data_d.bytes[0] = TAG_DEC16;
        data_d.bytes[1] = {s[2:0], v[12:8]};
        data_d.bytes[2] = v[7:0];
        data_d.cnt      = CntW'(3);
      end
      KIND_DEC24: begin
        data_d.bytes[0] = TAG_DEC24;
        data_d.bytes[1] = {s[3:0], v[19:16]};
        data_d.bytes[2] = v[15:8];
        data_d.bytes[3] = v[7:0];
        data_d.cnt      = CntW'(4);
      end
      KIND_DEC32: begin
        data_d.bytes[0] = TAG_DEC32;
        data_d.bytes[1] = {s[4:0], v[26:24]};
        data_d.bytes[2] = v[23:16];
        data_d.bytes[3] = v[15:8];
        data_d.bytes[4] = v[7:0];
        data_d.cnt      = CntW'(5);
      end
      default: data_d.err = 1'b1;
    endcase
    // replace with a single empty error byte
    if (in_i.err) begin
      data_d = '{err: 1'b1, bytes: '0, cnt: CntW'(1)};
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hw/rtl/tfbe_serial.sv =====
// Third stage: shift the packed bytes out one transfer per cycle while the output is ready.
// Depends on tfbe_pkg.
module tfbe_serial (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tfbe_pkg::pk_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o,
  output logic          out_err_o
);
  import tfbe_pkg::*;

  logic                     valid_q;
  logic [MaxBytes-1:0][7:0] bytes_q;
  logic [CntW-1:0]          cnt_q;
  logic                     err_q;
  logic                     last;
  logic                     take;

  assign last        = (cnt_q == CntW'(1));
  assign take        = valid_q && out_ready_i;
  assign in_ready_o  = !valid_q || (take && last);
  assign out_valid_o = valid_q;
  assign out_byte_o  = bytes_q[0];
  assign out_last_o  = last;
  assign out_err_o   = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      bytes_q <= in_i.bytes;
      cnt_q   <= in_i.cnt;
      err_q   <= in_i.err;
    end else if (take && !last) begin
      bytes_q <= {8'h00, bytes_q[MaxBytes-1:1]};
      cnt_q   <= cnt_q - CntW'(1);
    end
  end

endmodule
